/* hw/rtl/timing_bit_preamble_deframer_assert.svh */
// Assertion macros for the deframer
`ifndef TIMING_BIT_PREAMBLE_DEFRAMER_ASSERT_SVH
`define TIMING_BIT_PREAMBLE_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define TBPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TBPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define TBPD_ASSERT(label, prop, msg)
`define TBPD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* hw/rtl/tbpd_pkg.sv */
package tbpd_pkg;

    typedef enum logic [1:0] {
        PHASE_HUNT_FIRST  = 2'd0,
        PHASE_HUNT_SECOND = 2'd1,
        PHASE_SYNCED      = 2'd2
    } phase_t;

    localparam logic [7:0]  PreambleByte   = 8'hAA;
    localparam logic [7:0]  EndByte        = 8'h00;
    localparam logic [15:0] ThresholdReset = 16'd506;
    localparam logic [2:0]  LastBit        = 3'd7;

    localparam logic [2:0] EvFirstMismatch  = 3'd0;
    localparam logic [2:0] EvSecondMismatch = 3'd1;
    localparam logic [2:0] EvSynced         = 3'd2;
    localparam logic [2:0] EvMessage        = 3'd3;
    localparam logic [2:0] EvEnd            = 3'd4;

endpackage

/* hw/rtl/timing_bit_preamble_deframer.sv */
// An accepted sample is held in the input register; a result for the byte that it completes is
// loaded from there into the result register, where it is held until taken.
// Throughput: one latency sample per clock; the input register stalls only while it holds a
// sample that completes a byte with a result and the result register is full and not taken.
// Reset: synchronous, active low; clears phase, bit count, partial byte and valids,
// and loads hit_threshold with 506.
`include "timing_bit_preamble_deframer_assert.svh"

module timing_bit_preamble_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,      // hit_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [15:0] reload_latency
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] byte_value
    output logic [2:0]  m_tuser        // [2:0] event_kind
);
    import tbpd_pkg::*;

    logic [15:0] threshold_reg;
    logic        in_valid_reg;
    logic [15:0] in_latency_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [7:0]  shift_reg, shift_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [2:0]  out_kind_reg;

    logic        hit_bit;
    logic [7:0]  assembled;
    logic        byte_done;
    logic        emit;
    logic [2:0]  kind;
    logic        advance;
    logic        end_taken;

    assign cfg_ready = 1'b1;
    assign hit_bit   = in_latency_reg < threshold_reg;
    assign assembled = {shift_reg[6:0], hit_bit};
    assign byte_done = bit_pos_reg == LastBit;
    assign advance   = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign end_taken = advance && emit && (kind == EvEnd);

    always_comb begin
        phase_next = phase_reg;
        if (advance && byte_done) begin
            unique case (phase_reg)
                PHASE_HUNT_SECOND: begin
                    phase_next = (assembled == PreambleByte) ? PHASE_SYNCED : PHASE_HUNT_FIRST;
                end
                PHASE_SYNCED: begin
                    phase_next = (assembled == EndByte) ? PHASE_HUNT_FIRST : PHASE_SYNCED;
                end
                default: begin
                    phase_next = (assembled == PreambleByte) ? PHASE_HUNT_SECOND
                                                             : PHASE_HUNT_FIRST;
                end
            endcase
        end
    end

    always_comb begin
        emit = 1'b0;
        kind = EvFirstMismatch;
        if (byte_done) begin
            unique case (phase_reg)
                PHASE_HUNT_SECOND: begin
                    emit = 1'b1;
                    kind = (assembled == PreambleByte) ? EvSynced : EvSecondMismatch;
                end
                PHASE_SYNCED: begin
                    emit = 1'b1;
                    kind = (assembled == EndByte) ? EvEnd : EvMessage;
                end
                default: begin
                    emit = assembled != PreambleByte;
                    kind = EvFirstMismatch;
                end
            endcase
        end
    end

    always_comb begin
        bit_pos_next   = bit_pos_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (advance) begin
            bit_pos_next = bit_pos_reg + 3'd1;
            shift_next   = byte_done ? 8'd0 : assembled;
            if (emit) begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= ThresholdReset;
            in_valid_reg  <= 1'b0;
            phase_reg     <= PHASE_HUNT_FIRST;
            bit_pos_reg   <= 3'd0;
            shift_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                threshold_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            phase_reg     <= phase_next;
            bit_pos_reg   <= bit_pos_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload registers until loaded
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_latency_reg <= s_tdata;
        end
        if (advance && emit) begin
            out_byte_reg <= assembled;
            out_kind_reg <= kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;

    `TBPD_ASSERT(a_emit_on_byte, advance && emit |-> byte_done, "result without a completed byte")
    `TBPD_ASSERT(a_emit_loads, advance && emit |=> out_valid_reg, "result request lost")
    `TBPD_ASSERT(a_end_hunts, end_taken |=> phase_reg == PHASE_HUNT_FIRST, "end kept sync")
    `TBPD_ASSERT(a_sync_phase, kind == EvSynced |-> phase_reg == PHASE_HUNT_SECOND, "early sync")
    `TBPD_ASSERT(a_shift_clear, bit_pos_reg == 3'd0 |-> shift_reg == 8'd0, "stale bits")

endmodule

/* dv/timing_bit_preamble_deframer_chk.sv */
`timescale 1ns / 100ps

module timing_bit_preamble_deframer_chk
    import tbpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [2:0]  m_tuser,
    output int          mismatches,
    output int          awaited,
    output int          bytes_seen
);

    typedef struct packed {
        logic [7:0] value;
        logic [2:0] kind;
    } byte_event_t;

    byte_event_t awaited_events[$];

    logic [15:0] hit_threshold;
    phase_t      frame_phase;
    logic [2:0]  bits_held;
    logic [7:0]  partial_byte;

    task automatic absorb_latency(input logic [15:0] latency);
        logic [7:0] assembled;
        assembled = {partial_byte[6:0], latency < hit_threshold};
        if (bits_held != LastBit) begin
            bits_held    = bits_held + 3'd1;
            partial_byte = assembled;
        end else begin
            bits_held    = '0;
            partial_byte = '0;
            case (frame_phase)
                PHASE_HUNT_SECOND: begin
                    if (assembled == PreambleByte) begin
                        frame_phase = PHASE_SYNCED;
                        awaited_events.push_back('{value: assembled, kind: EvSynced});
                    end else begin
                        frame_phase = PHASE_HUNT_FIRST;
                        awaited_events.push_back('{value: assembled, kind: EvSecondMismatch});
                    end
                end
                PHASE_SYNCED: begin
                    if (assembled == EndByte) begin
                        frame_phase = PHASE_HUNT_FIRST;
                        awaited_events.push_back('{value: assembled, kind: EvEnd});
                    end else begin
                        awaited_events.push_back('{value: assembled, kind: EvMessage});
                    end
                end
                default: begin
                    if (assembled == PreambleByte) begin
                        frame_phase = PHASE_HUNT_SECOND;
                    end else begin
                        frame_phase = PHASE_HUNT_FIRST;
                        awaited_events.push_back('{value: assembled, kind: EvFirstMismatch});
                    end
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin : watch
        byte_event_t oldest;
        if (!aresetn) begin
            hit_threshold = ThresholdReset;
            frame_phase   = PHASE_HUNT_FIRST;
            bits_held     = '0;
            partial_byte  = '0;
            mismatches    = 0;
            bytes_seen    = 0;
            awaited_events.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_events.size() == 0) begin
                    $error("unexpected result: byte_value %h event_kind %0d", m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    oldest = awaited_events.pop_front();
                    bytes_seen++;
                    if (m_tdata !== oldest.value) begin
                        $error("byte_value: expected %h, got %h", oldest.value, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== oldest.kind) begin
                        $error("event_kind: expected %0d, got %0d", oldest.kind, m_tuser);
                        mismatches++;
                    end
                end
            end
            // a new threshold applies from the next sample on
            if (s_tvalid && s_tready) absorb_latency(s_tdata);
            if (cfg_valid && cfg_ready) hit_threshold = cfg_data;
        end
        awaited = awaited_events.size();
    end

endmodule

/* dv/timing_bit_preamble_deframer_tb.sv */
`timescale 1ns / 100ps

module timing_bit_preamble_deframer_tb;
    import tbpd_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;

    int mismatches;
    int awaited;
    int bytes_seen;

    int          sender_idle_pct = 0;
    int          stall_pct       = 0;
    int          samples_sent    = 0;
    int          threshold_writes = 0;
    logic [15:0] hit_threshold   = ThresholdReset;

    timing_bit_preamble_deframer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    timing_bit_preamble_deframer_chk i_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaited    (awaited),
        .bytes_seen (bytes_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_latency(input logic [15:0] latency);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        // hold the request until taken
        s_tvalid <= 1'b1;
        s_tdata  <= latency;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    function automatic logic [15:0] latency_for_bit(input logic bit_value);
        if (bit_value && hit_threshold != 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'd0;
                1:       return hit_threshold - 16'd1;
                default: return 16'($urandom_range(0, hit_threshold - 1));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return hit_threshold;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(hit_threshold, 16'hFFFF));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] value);
        for (int i = 7; i >= 0; i--) send_latency(latency_for_bit(value[i]));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (4) @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        hit_threshold = value;
        threshold_writes++;
    endtask

    task automatic send_traffic(input int sample_count);
        int first_sample;
        int pick;
        first_sample = samples_sent;
        while (samples_sent - first_sample < sample_count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_byte(PreambleByte);
                send_byte(PreambleByte);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(1, 255)));
                send_byte(EndByte);
            end else if (pick < 70) begin
                send_byte(PreambleByte);
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 7)) send_latency(16'($urandom_range(0, 16'hFFFF)));
            end
        end
    endtask

    initial begin
        logic [15:0] settings [5];
        settings = '{16'hFFFF, 16'd1, 16'($urandom_range(2, 16'hFFFE)), ThresholdReset,
                     16'($urandom_range(1, 4000))};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // preamble byte with the field extremes and the threshold boundary
        send_latency(16'd0);
        send_latency(16'hFFFF);
        send_latency(ThresholdReset - 16'd1);
        send_latency(ThresholdReset);
        send_latency(16'd0);
        send_latency(16'hFFFF);
        send_latency(ThresholdReset - 16'd1);
        send_latency(ThresholdReset);
        send_byte(8'h55);
        send_byte(PreambleByte);
        send_byte(PreambleByte);
        send_byte(8'h80);
        send_byte(EndByte);

        set_threshold(16'd0);
        send_byte(PreambleByte);
        send_byte(8'hFF);

        for (int p = 0; p < 5; p++) begin
            set_threshold(settings[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 70; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 70; end
                default: begin sender_idle_pct = 7; stall_pct = 7; end
            endcase
            send_traffic(170);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("%0d latency samples across %0d threshold settings and four pacing modes",
                 samples_sent, threshold_writes + 1);
        $display("%0d framing events checked against the predicted byte stream", bytes_seen);
        if (mismatches == 0) begin
            $display("timing_bit_preamble_deframer_tb: clean");
        end else begin
            $display("timing_bit_preamble_deframer_tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timing_bit_preamble_deframer_tb: errors");
        $finish;
    end

endmodule
